// ===== rtl/bbanf_pkg.sv =====
// Package for the next-fit bitmap lot allocator.
// Holds field widths, action, status and register codes, and the map and scan types.
// No dependencies.
package bbanf_pkg;

  localparam int WORD_W    = 64;
  localparam int OFS_W     = 6;
  localparam int ACT_W     = 2;
  localparam int IDX_W     = 12;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GRANT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WPROT  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOT_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] in_use;
    logic [WORD_W-1:0] free;
  } map_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] bits;
    logic [OFS_W-1:0]  lo;
    logic [OFS_W-1:0]  hi;
  } scan_req_t;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] pos;
  } scan_res_t;

endpackage

// ===== rtl/bitmap_block_allocator_next_fit_core.sv =====
// Next-fit lot allocator: free and in-use maps in a row store, scanned one
// 64-lot row per cycle by a shared find-first unit under a sequencer.
// Flow: free and grant go read, update, done; allocate goes read, then scans rows from the
// hint, once more from lot 0 if none is free, then done; rejected words go straight to done. One word at a time.
// Reset: clears both maps row by row, not ready meanwhile.
// Depends on bbanf_pkg, bbanf_map_ram and bbanf_scan_unit.
module bitmap_block_allocator_next_fit_core #(
  parameter int MAX_LOTS = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bbanf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bbanf_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bbanf_pkg::ACT_W-1:0]        action_i,
  input  logic [bbanf_pkg::IDX_W-1:0]        lot_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bbanf_pkg::STAT_W-1:0]       status_o,
  output logic [bbanf_pkg::IDX_W-1:0]        allocated_lot_o
);
  import bbanf_pkg::*;

  localparam int WORDS = (MAX_LOTS + WORD_W - 1) / WORD_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = WA_W + OFS_W;
  localparam int BW    = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN, ST_UPD, ST_DONE
  } state_e;

  state_e              state_q;
  logic [WA_W-1:0]     word_q;
  logic                pass_q;
  logic [IW-1:0]       from_q;
  logic [ACT_W-1:0]    act_q;
  logic [IW-1:0]       idx_q;
  logic [IW-1:0]       hint_q;
  logic [CNT_W-1:0]    lot_count_q;
  logic                wp_q;
  logic [STAT_W-1:0]   res_status_q;
  logic [IW-1:0]       res_lot_q;
  logic                out_valid_q;
  logic [STAT_W-1:0]   out_status_q;
  logic [IDX_W-1:0]    out_lot_q;

  logic [BW-1:0]       lc_ext;
  logic [BW-1:0]       max_ext;
  logic [BW-1:0]       bnd_full;
  logic [IW:0]         end_w;
  logic [IW:0]         last_full;
  logic [IW-1:0]       last_w;
  logic [IW-1:0]       in_idx;
  logic                in_idx_oor;
  logic                hint_past;

  logic                ram_we;
  logic [WA_W-1:0]     ram_waddr;
  map_word_t           ram_wdata;
  logic [WA_W-1:0]     ram_raddr;
  map_word_t           ram_rdata;

  scan_req_t           scan_req;
  scan_res_t           scan_res;
  logic [WORD_W-1:0]   hit_oh;
  logic [WORD_W-1:0]   upd_oh;
  logic [IW-1:0]       hit_idx;
  logic                at_last;
  logic                upd_inuse;
  logic                accept;

  assign lc_ext    = BW'(lot_count_q);
  assign max_ext   = BW'(MAX_LOTS);
  assign bnd_full  = (lc_ext > max_ext) ? max_ext : lc_ext;
  assign end_w     = bnd_full[IW:0];
  assign last_full = end_w - (IW + 1)'(1);
  assign last_w    = last_full[IW-1:0];

  assign in_idx     = IW'(lot_index_i);
  assign in_idx_oor = BW'(lot_index_i) >= BW'(end_w);
  assign hint_past  = BW'(hint_q) >= BW'(end_w);

  assign accept  = in_valid_i && in_ready_o;
  assign at_last = word_q == last_w[IW-1:OFS_W];

  assign scan_req.bits = ram_rdata.free;
  assign scan_req.lo   = (word_q == from_q[IW-1:OFS_W]) ? from_q[OFS_W-1:0] : '0;
  assign scan_req.hi   = at_last ? last_w[OFS_W-1:0] : OFS_W'(WORD_W - 1);

  bbanf_scan_unit u_scan (
    .req_i (scan_req),
    .res_o (scan_res)
  );

  assign hit_oh    = WORD_W'(1) << scan_res.pos;
  assign hit_idx   = {word_q, scan_res.pos};
  assign upd_oh    = WORD_W'(1) << idx_q[OFS_W-1:0];
  assign upd_inuse = |(ram_rdata.in_use & upd_oh);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = ram_rdata;
    ram_raddr = word_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_SCAN: begin
        ram_raddr        = word_q + WA_W'(1);
        ram_we           = scan_res.found;
        ram_wdata.free   = ram_rdata.free & ~hit_oh;
        ram_wdata.in_use = ram_rdata.in_use | hit_oh;
      end
      ST_UPD: begin
        if (act_q == ACT_GRANT) begin
          ram_we         = 1'b1;
          ram_wdata.free = ram_rdata.free | upd_oh;
        end else begin
          ram_we           = upd_inuse;
          ram_wdata.free   = ram_rdata.free | upd_oh;
          ram_wdata.in_use = ram_rdata.in_use & ~upd_oh;
        end
      end
      default: begin
      end
    endcase
  end

  bbanf_map_ram #(
    .DEPTH  (WORDS),
    .ADDR_W (WA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      word_q       <= '0;
      pass_q       <= 1'b0;
      from_q       <= '0;
      act_q        <= ACT_ALLOC;
      idx_q        <= '0;
      hint_q       <= '0;
      lot_count_q  <= CNT_W'(4096);
      wp_q         <= 1'b0;
      res_status_q <= STAT_OK;
      res_lot_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_lot_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOT_COUNT:     lot_count_q <= cfg_data_i;
          CFG_WRITE_PROTECT: wp_q        <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (word_q == WA_W'(WORDS - 1)) begin
            word_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            word_q <= word_q + WA_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            act_q        <= action_i;
            idx_q        <= in_idx;
            res_status_q <= STAT_OK;
            res_lot_q    <= '0;
            unique case (action_i)
              ACT_ALLOC: begin
                if (wp_q) begin
                  res_status_q <= STAT_WPROT;
                  state_q      <= ST_DONE;
                end else if (end_w == '0) begin
                  res_status_q <= STAT_NOFREE;
                  hint_q       <= '0;
                  state_q      <= ST_DONE;
                end else if (hint_past) begin
                  pass_q  <= 1'b1;
                  from_q  <= '0;
                  word_q  <= '0;
                  state_q <= ST_READ;
                end else begin
                  pass_q  <= 1'b0;
                  from_q  <= hint_q;
                  word_q  <= hint_q[IW-1:OFS_W];
                  state_q <= ST_READ;
                end
              end
              ACT_FREE, ACT_GRANT: begin
                if (in_idx_oor) begin
                  res_status_q <= STAT_RANGE;
                  state_q      <= ST_DONE;
                end else begin
                  word_q  <= in_idx[IW-1:OFS_W];
                  state_q <= ST_READ;
                end
              end
              default: begin
                res_status_q <= STAT_RANGE;
                state_q      <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          state_q <= (act_q == ACT_ALLOC) ? ST_SCAN : ST_UPD;
        end
        ST_SCAN: begin
          if (scan_res.found) begin
            hint_q    <= hit_idx;
            res_lot_q <= hit_idx;
            state_q   <= ST_DONE;
          end else if (!at_last) begin
            word_q <= word_q + WA_W'(1);
          end else if (!pass_q) begin
            pass_q  <= 1'b1;
            from_q  <= '0;
            word_q  <= '0;
            state_q <= ST_READ;
          end else begin
            hint_q       <= '0;
            res_status_q <= STAT_NOFREE;
            state_q      <= ST_DONE;
          end
        end
        ST_UPD: begin
          if (act_q == ACT_FREE && idx_q > hint_q) begin
            hint_q <= idx_q;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_lot_q    <= IDX_W'(res_lot_q);
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign allocated_lot_o = out_lot_q;

  a_lot_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> allocated_lot_o == '0)
    else $error("lot reported on a failed word");

  a_hit_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_res.found) |-> BW'(hit_idx) < BW'(end_w))
    else $error("scan hit beyond lot count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready while a word is in progress");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("finished word not presented");

endmodule

// ===== rtl/bbanf_map_ram.sv =====
// Word store for the free and in-use maps, one 64-lot row per entry.
// One write and one registered read port. Depends on bbanf_pkg.
module bbanf_map_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  bbanf_pkg::map_word_t  wdata_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output bbanf_pkg::map_word_t  rdata_o
);
  import bbanf_pkg::*;

  map_word_t mem [DEPTH];
  map_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bbanf_scan_unit.sv =====
// Shared find-first unit: masks one map row to a bit window and returns
// the lowest set bit. Depends on bbanf_pkg.
module bbanf_scan_unit (
  input  bbanf_pkg::scan_req_t req_i,
  output bbanf_pkg::scan_res_t res_o
);
  import bbanf_pkg::*;

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] masked;
  logic [OFS_W-1:0]  pos;

  assign lo_mask = {WORD_W{1'b1}} << req_i.lo;
  assign hi_mask = {WORD_W{1'b1}} >> (OFS_W'(WORD_W - 1) - req_i.hi);
  assign masked  = req_i.bits & lo_mask & hi_mask;

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        pos = OFS_W'(i);
      end
    end
  end

  assign res_o.found = |masked;
  assign res_o.pos   = pos;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for bitmap_block_allocator_next_fit_core: directed and random allocate, free and
// grant words under varying lot counts and write protection, checked by a scoreboard class.
// Depends on bbanf_pkg and the allocator core.
module testbench;
  import bbanf_pkg::*;

  localparam int MAX_LOTS       = 4096;
  localparam int DRAIN_CYCLES   = 2 * ((MAX_LOTS + 63) / 64) + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 53;

  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  lot;
  } lot_reply_t;

  class lot_scoreboard;
    bit          free_map   [MAX_LOTS];
    bit          in_use_map [MAX_LOTS];
    int unsigned hint;
    int unsigned lot_limit;
    bit          protect;
    lot_reply_t  replies [$];
    int          errors;

    function new();
      hint      = 0;
      lot_limit = MAX_LOTS;
      protect   = 1'b0;
      errors    = 0;
    endfunction

    function int unsigned span();
      return (lot_limit > MAX_LOTS) ? MAX_LOTS : lot_limit;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      if (idx == CFG_LOT_COUNT) begin
        lot_limit = data;
      end else begin
        protect = data[0];
      end
    endfunction

    function bit find_free(int unsigned from, int unsigned upto, output int unsigned hit);
      for (int unsigned i = from; i < upto; i++) begin
        if (free_map[i]) begin
          hit = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx);
      lot_reply_t  r;
      int unsigned span_now;
      int unsigned hit;
      bit          found;
      span_now = span();
      r.status = STAT_OK;
      r.lot    = '0;
      case (act)
        ACT_ALLOC: begin
          if (protect) begin
            r.status = STAT_WPROT;
          end else begin
            found = find_free(hint, span_now, hit);
            if (!found) begin
              hint  = 0;
              found = find_free(0, span_now, hit);
            end
            if (found) begin
              free_map[hit]   = 1'b0;
              in_use_map[hit] = 1'b1;
              hint            = hit;
              r.lot           = IDX_W'(hit);
            end else begin
              r.status = STAT_NOFREE;
            end
          end
        end
        ACT_FREE: begin
          if (idx >= span_now) begin
            r.status = STAT_RANGE;
          end else begin
            if (in_use_map[idx]) begin
              in_use_map[idx] = 1'b0;
              free_map[idx]   = 1'b1;
            end
            if (idx > hint) hint = idx;
          end
        end
        ACT_GRANT: begin
          if (idx >= span_now) r.status = STAT_RANGE;
          else free_map[idx] = 1'b1;
        end
        default: begin
          r.status = STAT_RANGE;
        end
      endcase
      replies.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] lot);
      lot_reply_t want;
      if (replies.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d lot %0d", $time, status, lot);
        return;
      end
      want = replies.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
      if (lot !== want.lot) begin
        errors++;
        $display("%0t: allocated_lot expected %0d actual %0d", $time, want.lot, lot);
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CNT_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [ACT_W-1:0]     action_i    = '0;
  logic [IDX_W-1:0]     lot_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic [IDX_W-1:0]     allocated_lot_o;

  lot_scoreboard lots = new();
  bit            idling = 1'b1;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  bitmap_block_allocator_next_fit_core #(
    .MAX_LOTS(MAX_LOTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .lot_index_i    (lot_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .allocated_lot_o(allocated_lot_o)
  );

  always #5 clk_i = ~clk_i;

  // stall the result side in short bursts while idling is set
  always @(posedge clk_i) begin
    if (stall_left == 0 && idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) lots.note_word(action_i, lot_index_i);
      if (out_valid_o && out_ready_i) lots.check_result(status_o, allocated_lot_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    lot_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lots.replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CNT_W-1:0] count, input bit prot);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOT_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    lots.set_reg(CFG_LOT_COUNT, count);
    cfg_idx_i  <= CFG_WRITE_PROTECT;
    cfg_data_i <= CNT_W'(prot);
    @(posedge clk_i);
    lots.set_reg(CFG_WRITE_PROTECT, CNT_W'(prot));
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] index_in_range();
    int unsigned span_now;
    span_now = lots.span();
    if (span_now == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, span_now - 1));
  endfunction

  task automatic random_word();
    int unsigned      pick;
    int unsigned      span_now;
    int unsigned      start;
    logic [IDX_W-1:0] idx;
    pick     = $urandom_range(0, 99);
    span_now = lots.span();
    idx      = index_in_range();
    if (pick < 35) begin
      send_word(ACT_ALLOC, IDX_W'($urandom));
    end else if (pick < 60) begin
      start = idx;
      for (int unsigned k = 0; k < span_now; k++) begin
        if (lots.in_use_map[(start + k) % span_now]) begin
          idx = IDX_W'((start + k) % span_now);
          break;
        end
      end
      send_word(ACT_FREE, idx);
    end else if (pick < 85) begin
      send_word(ACT_GRANT, idx);
    end else if (pick < 95) begin
      send_word(pick[0] ? ACT_FREE : ACT_GRANT, IDX_W'($urandom));
    end else begin
      send_word(ACT_UNKNOWN, IDX_W'($urandom));
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input bit prot, input bit with_idle);
    settle();
    idling = with_idle;
    write_regs(count, prot);
    repeat (RANDOM_WORDS) random_word();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);

    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_FREE, 12'h000);
    send_word(ACT_FREE, 12'hFFF);
    send_word(ACT_GRANT, 12'hFFF);
    send_word(ACT_GRANT, 12'h000);
    send_word(ACT_GRANT, 12'h555);
    send_word(ACT_GRANT, 12'hAAA);
    send_word(ACT_ALLOC, 12'hFFF);
    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_FREE, 12'hFFF);
    send_word(ACT_FREE, 12'hFFF);
    send_word(ACT_UNKNOWN, 12'hFFF);

    settle();
    write_regs(13'd8, 1'b0);
    send_word(ACT_GRANT, 12'd8);
    send_word(ACT_FREE, 12'd8);
    send_word(ACT_GRANT, 12'd7);
    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_ALLOC, 12'h000);

    settle();
    write_regs(13'd8, 1'b1);
    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_FREE, 12'd7);

    settle();
    write_regs(13'd0, 1'b0);
    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_GRANT, 12'h000);
    send_word(ACT_FREE, 12'h000);

    settle();
    write_regs(13'h1FFF, 1'b0);
    send_word(ACT_ALLOC, 12'h000);
    send_word(ACT_GRANT, 12'hFFF);
    send_word(ACT_ALLOC, 12'h000);

    run_phase(13'd4096, 1'b0, 1'b1);
    run_phase(13'd100,  1'b0, 1'b0);
    run_phase(13'h1FFF, 1'b0, 1'b1);
    run_phase(13'd4096, 1'b1, 1'b1);
    run_phase(13'd1,    1'b0, 1'b1);
    run_phase(13'd5000, 1'b0, 1'b0);
    run_phase(13'd4095, 1'b0, 1'b1);
    run_phase(13'd64,   1'b0, 1'b1);
    run_phase(13'd4096, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lots.errors == 0 && lots.replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bbanf_pkg.sv
rtl/bbanf_map_ram.sv
rtl/bbanf_scan_unit.sv
rtl/bitmap_block_allocator_next_fit_core.sv
verif/testbench.sv
